/* design/newick_pair_ancestor_time_defines.svh */
// ----------------------------------------------------------------------------
// Newick pair ancestor time: assertion macros
// Shorthand for the concurrent checks that the pair search uses. Every check
// runs on the rising edge of clk and stays quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEWICK_PAIR_ANCESTOR_TIME_DEFINES_SVH
`define NEWICK_PAIR_ANCESTOR_TIME_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPAT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/npat_pkg.sv */
// ----------------------------------------------------------------------------
// Newick pair ancestor time: shared package
// Walk and lexer codes, character codes, field widths, the token sideband
// that travels down the fraction pipeline, and small helper functions.
// ----------------------------------------------------------------------------
package npat_pkg;

	// Position of the tree walk.
	typedef enum logic [2:0] {
		PH_PRE,
		PH_SEEK,
		PH_CLIMB,
		PH_SCAN,
		PH_DONE
	} phase_t;

	// What the lexer is collecting at the moment.
	typedef enum logic [2:0] {
		LX_IDLE,
		LX_LABEL,
		LX_SKIP,
		LX_AWAIT,
		LX_WHOLE,
		LX_FRAC
	} lex_t;

	localparam int LABEL_W   = 14;
	localparam int WHOLE_W   = 16;
	localparam int FRAC_BITS = 32;
	localparam int TIME_W    = WHOLE_W + FRAC_BITS;
	localparam int CFG_IDX_W = 1;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_NINE = 8'd57;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_POINT   = 8'h2E;
	localparam logic [7:0] CH_COLON   = 8'h3A;

	localparam logic [LABEL_W-1:0] LABEL_MAX = '1;
	localparam logic [WHOLE_W-1:0] WHOLE_MAX = '1;
	localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SECOND = 1'b1;

	localparam logic [LABEL_W-1:0] SAMPLE_FIRST_RST  = 14'd1;
	localparam logic [LABEL_W-1:0] SAMPLE_SECOND_RST = 14'd2;

	// Everything of a length token except the fraction, whose width follows
	// the number of kept fraction digits.
	typedef struct packed {
		logic [WHOLE_W-1:0] whole;
		logic               last;
		logic               pair;
		logic               ovf;
	} tok_side_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
	endfunction

	function automatic logic [63:0] pow10(input logic [3:0] k);
		logic [63:0] p;
		case (k)
			4'd0:    p = 64'd1;
			4'd1:    p = 64'd10;
			4'd2:    p = 64'd100;
			4'd3:    p = 64'd1000;
			4'd4:    p = 64'd10000;
			4'd5:    p = 64'd100000;
			4'd6:    p = 64'd1000000;
			4'd7:    p = 64'd10000000;
			4'd8:    p = 64'd100000000;
			4'd9:    p = 64'd1000000000;
			4'd10:   p = 64'd10000000000;
			4'd11:   p = 64'd100000000000;
			4'd12:   p = 64'd1000000000000;
			4'd13:   p = 64'd10000000000000;
			4'd14:   p = 64'd100000000000000;
			4'd15:   p = 64'd1000000000000000;
			default: p = 64'd1;
		endcase
		return p;
	endfunction

	// Bits that hold 10^digits, which is also enough for any kept fraction.
	function automatic int frac_width(input int digits);
		return $clog2(pow10(4'(digits)));
	endfunction

endpackage

/* design/newick_pair_ancestor_time.sv */
// ----------------------------------------------------------------------------
// Newick pair ancestor time: top level
// Streams a Newick tree text and reports the summed branch lengths from the
// first sample leaf up to the node that joins it with the second sample.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle while the pipeline is not
// stalled, with no gaps needed between trees: the lexer works out all of its
// parse state for a byte combinationally. Each byte is an input transaction
// (tdata = the character, tlast = final byte of a tree); bytes before the
// first '(' are ignored. When a branch length closes, its decimal fraction
// enters a 32-stage pipeline that converts it to binary one quotient bit per
// stage, and an accumulator then adds it to the running sum, saturating at
// the 48-bit maximum. The byte marked tlast yields exactly one output
// transaction after passing the lexer register and the fraction converter,
// whose last stage feeds the accumulator and the output register directly.
// Other bytes yield nothing. If the output register holds a result that the
// sink has not taken, the whole pipeline stalls and s_axis_tready drops until
// it is taken. The two sample labels are written through the cfg port
// (index 0 = first sample, index 1 = second sample) and must only be changed
// while no tree is in flight; they reset to 1 and 2.
// ----------------------------------------------------------------------------
`include "newick_pair_ancestor_time_defines.svh"

module newick_pair_ancestor_time import npat_pkg::*; #(
	parameter int MAX_NESTING     = 255,
	parameter int FRACTION_DIGITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Text byte stream.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] text_byte
	input  logic                 s_axis_tlast,   // last_byte
	// Result stream.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TIME_W-1:0]    m_axis_tdata,   // [47:0] ancestor_time
	output logic [1:0]           m_axis_tuser,   // [0] pair_found, [1] overflow_seen
	// Register writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LABEL_W-1:0]   cfg_data
);

	localparam int FRAC_W = frac_width(FRACTION_DIGITS);
	localparam int POS_W  = $clog2(FRACTION_DIGITS + 1);

	// Pipeline advance. Every stage moves together, and only stalls when a
	// finished result is still waiting in the output register.
	logic en;

	logic [LABEL_W-1:0] sample_first_q;
	logic [LABEL_W-1:0] sample_second_q;

	logic              tok_valid;
	logic [FRAC_W-1:0] tok_frac;
	logic [POS_W-1:0]  tok_pos;
	tok_side_t         tok_side;

	logic                 div_valid;
	logic [FRAC_BITS-1:0] div_quo;
	tok_side_t            div_side;

	logic [TIME_W-1:0] sum_q;
	logic              sum_ovf_q;
	logic [TIME_W:0]   sum_total;
	logic              sum_sat;
	logic [TIME_W-1:0] sum_next;

	logic              out_valid_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_pair_q;
	logic              out_ovf_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// Sample registers. Writes must arrive only between trees; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_first_q  <= SAMPLE_FIRST_RST;
			sample_second_q <= SAMPLE_SECOND_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SAMPLE_FIRST:  sample_first_q  <= cfg_data;
				REG_SAMPLE_SECOND: sample_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	npat_lexer #(
		.MAX_NESTING    (MAX_NESTING),
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.FRAC_W         (FRAC_W),
		.POS_W          (POS_W)
	) u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.text_byte    (s_axis_tdata),
		.last_byte    (s_axis_tlast),
		.sample_first (sample_first_q),
		.sample_second(sample_second_q),
		.tok_valid    (tok_valid),
		.tok_frac     (tok_frac),
		.tok_pos      (tok_pos),
		.tok_side     (tok_side)
	);

	npat_frac_div #(
		.FRAC_W(FRAC_W),
		.POS_W (POS_W)
	) u_frac_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (tok_valid),
		.in_frac  (tok_frac),
		.in_pos   (tok_pos),
		.in_side  (tok_side),
		.out_valid(div_valid),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	// Tokens that carry no length bring a zero whole part and fraction, so
	// the accumulator can add every token it sees.
	assign sum_total = {1'b0, sum_q} + {1'b0, div_side.whole, div_quo};
	assign sum_sat   = sum_total[TIME_W];
	assign sum_next  = sum_sat ? TIME_MAX : sum_total[TIME_W-1:0];

	// The running sum restarts after the final token of a tree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			sum_ovf_q <= 1'b0;
		end else if (en && div_valid) begin
			if (div_side.last) begin
				sum_q     <= '0;
				sum_ovf_q <= 1'b0;
			end else begin
				sum_q     <= sum_next;
				sum_ovf_q <= sum_ovf_q || sum_sat;
			end
		end
	end

	// Output register. Whenever the pipeline advances, the old result has
	// been taken or was never there, so the register simply reloads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= div_valid && div_side.last;
	end

	always_ff @(posedge clk) begin
		if (en && div_valid && div_side.last) begin
			out_time_q <= sum_next;
			out_pair_q <= div_side.pair;
			out_ovf_q  <= div_side.ovf || sum_ovf_q || sum_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_time_q;
	assign m_axis_tuser  = {out_ovf_q, out_pair_q};

	// A result can only show up right after a final token reached the end of
	// the converter.
	`NPAT_ASSERT_NEXT(a_result_needs_token, en && !(div_valid && div_side.last), !m_axis_tvalid, "result without a final token")

	// The sum starts from zero for the next tree.
	`NPAT_ASSERT_NEXT(a_sum_cleared, en && div_valid && div_side.last, (sum_q == '0) && !sum_ovf_q, "sum not cleared after a tree")

	// Once the sum has saturated it stays pinned at the maximum.
	`NPAT_ASSERT_SAME(a_sum_pinned, sum_ovf_q, sum_q == TIME_MAX, "saturated sum left the maximum")

endmodule

/* design/npat_lexer.sv */
// ----------------------------------------------------------------------------
// Newick pair ancestor time: byte lexer and tree walk
// Updates the whole parse state for one text byte per cycle unless stalled and
// registers a token whenever a branch length is complete or the tree ends.
// ----------------------------------------------------------------------------
module npat_lexer import npat_pkg::*; #(
	parameter int MAX_NESTING     = 255,
	parameter int FRACTION_DIGITS = 10,
	parameter int FRAC_W          = 34,
	parameter int POS_W           = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [7:0]         text_byte,
	input  logic               last_byte,
	input  logic [LABEL_W-1:0] sample_first,
	input  logic [LABEL_W-1:0] sample_second,
	output logic               tok_valid,
	output logic [FRAC_W-1:0]  tok_frac,
	output logic [POS_W-1:0]   tok_pos,
	output tok_side_t          tok_side
);

	localparam int NEST_W = $clog2(MAX_NESTING + 1);

	typedef struct packed {
		phase_t             phase;
		lex_t               lex;
		logic [LABEL_W-1:0] label;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [POS_W-1:0]   pos;
		logic [NEST_W-1:0]  nest;
		logic [LABEL_W-1:0] other;
		logic               pair;
		logic               ovf;
	} walk_t;

	// PH_PRE and LX_IDLE both encode as zero, so the cleared walk is all zeros.
	localparam walk_t WALK_RST = '0;

	walk_t walk_q, walk_d;
	walk_t walk_p1, walk_p2, walk_p;
	logic  again1, again2;
	logic  accept;

	logic              tok_valid_s1;
	logic [FRAC_W-1:0] tok_frac_s1;
	logic [POS_W-1:0]  tok_pos_s1;
	tok_side_t         tok_side_s1;

	logic              term;
	logic              add_term, add_last;
	logic              tok_valid_d;
	logic [FRAC_W-1:0] tok_frac_d;
	logic [POS_W-1:0]  tok_pos_d;
	tok_side_t         tok_side_d;

	// Reaction of the walk to a byte that arrives while the lexer is idle.
	function automatic walk_t structural(input walk_t s, input logic [7:0] c);
		walk_t n;
		logic  dig;
		n   = s;
		dig = is_digit(c);
		case (s.phase)
			PH_PRE: begin
				if (c == CH_OPEN)
					n.phase = PH_SEEK;
			end
			PH_SEEK: begin
				if (c == CH_CLOSE) begin
					n.lex = LX_SKIP;
				end else if (dig) begin
					n.label = LABEL_W'(c[3:0]);
					n.lex   = LX_LABEL;
				end
			end
			PH_CLIMB: begin
				if (c == CH_COMMA) begin
					n.phase = PH_SCAN;
					n.nest  = NEST_W'(1);
				end else if (c == CH_CLOSE) begin
					n.lex = LX_AWAIT;
				end
			end
			PH_SCAN: begin
				if (dig) begin
					n.label = LABEL_W'(c[3:0]);
					n.lex   = LX_LABEL;
				end else if (c == CH_OPEN) begin
					if (s.nest < NEST_W'(MAX_NESTING))
						n.nest = s.nest + NEST_W'(1);
					else
						n.ovf = 1'b1;
				end else if (c == CH_CLOSE) begin
					if (s.nest <= NEST_W'(1)) begin
						n.nest  = '0;
						n.phase = PH_CLIMB;
						n.lex   = LX_AWAIT;
					end else begin
						n.nest = s.nest - NEST_W'(1);
						n.lex  = LX_SKIP;
					end
				end
			end
			default: ;
		endcase
		return n;
	endfunction

	// A label has ended: decide whether it starts the climb or closes the pair.
	function automatic walk_t end_label(input walk_t s, input logic [LABEL_W-1:0] sf,
			input logic [LABEL_W-1:0] ss);
		walk_t n;
		n = s;
		if (s.phase == PH_SEEK) begin
			if (s.label == sf) begin
				n.other = ss;
				n.phase = PH_CLIMB;
				n.lex   = LX_AWAIT;
			end else if (s.label == ss) begin
				n.other = sf;
				n.phase = PH_CLIMB;
				n.lex   = LX_AWAIT;
			end else begin
				n.lex = LX_SKIP;
			end
		end else if ((s.phase == PH_SCAN) && (s.label == s.other)) begin
			n.pair  = 1'b1;
			n.phase = PH_DONE;
			n.lex   = LX_IDLE;
		end else begin
			n.lex = LX_SKIP;
		end
		return n;
	endfunction

	// First look at a byte, in whatever mode the lexer is in.
	function automatic walk_t lex_pass(input walk_t s, input logic [7:0] c,
			input logic [LABEL_W-1:0] sf, input logic [LABEL_W-1:0] ss, output logic again);
		walk_t               n;
		logic                dig, trm;
		logic [LABEL_W+3:0]  lab_x;
		logic [WHOLE_W+3:0]  whole_x;
		logic [FRAC_W+3:0]   frac_x;
		n       = s;
		again   = 1'b0;
		dig     = is_digit(c);
		trm     = (c == CH_COMMA) || (c == CH_CLOSE);
		lab_x   = ({4'b0, s.label} << 3) + ({4'b0, s.label} << 1) + (LABEL_W + 4)'(c[3:0]);
		whole_x = ({4'b0, s.whole} << 3) + ({4'b0, s.whole} << 1) + (WHOLE_W + 4)'(c[3:0]);
		frac_x  = ({4'b0, s.frac} << 3) + ({4'b0, s.frac} << 1) + (FRAC_W + 4)'(c[3:0]);
		case (s.lex)
			LX_LABEL: begin
				if (dig) begin
					if (lab_x > (LABEL_W + 4)'(LABEL_MAX))
						n.label = LABEL_MAX;
					else
						n.label = lab_x[LABEL_W-1:0];
				end else begin
					n     = end_label(s, sf, ss);
					again = 1'b1;
				end
			end
			LX_SKIP: begin
				if (trm) begin
					n.lex = LX_IDLE;
					again = 1'b1;
				end
			end
			LX_AWAIT: begin
				if (c == CH_COLON) begin
					n.whole = '0;
					n.frac  = '0;
					n.pos   = '0;
					n.lex   = LX_WHOLE;
				end else if (trm) begin
					n.lex = LX_IDLE;
					again = 1'b1;
				end
			end
			LX_WHOLE, LX_FRAC: begin
				if (trm) begin
					n.lex = LX_IDLE;
					again = 1'b1;
				end else if (dig) begin
					if (s.lex == LX_WHOLE) begin
						if (whole_x > (WHOLE_W + 4)'(WHOLE_MAX)) begin
							n.whole = WHOLE_MAX;
							n.ovf   = 1'b1;
						end else begin
							n.whole = whole_x[WHOLE_W-1:0];
						end
					end else if (s.pos < POS_W'(FRACTION_DIGITS)) begin
						n.frac = frac_x[FRAC_W-1:0];
						n.pos  = s.pos + POS_W'(1);
					end
				end else if ((c == CH_POINT) && (s.lex == LX_WHOLE)) begin
					n.lex = LX_FRAC;
				end
			end
			default: begin
				n.lex = LX_IDLE;
				n     = structural(n, c);
			end
		endcase
		return n;
	endfunction

	// Later looks at the same byte. It is never a digit here and the lexer is
	// skipping, awaiting a colon or idle.
	function automatic walk_t redo_pass(input walk_t s, input logic [7:0] c,
			output logic again);
		walk_t n;
		logic  trm;
		n     = s;
		again = 1'b0;
		trm   = (c == CH_COMMA) || (c == CH_CLOSE);
		case (s.lex)
			LX_SKIP: begin
				if (trm) begin
					n.lex = LX_IDLE;
					again = 1'b1;
				end
			end
			LX_AWAIT: begin
				if (c == CH_COLON) begin
					n.whole = '0;
					n.frac  = '0;
					n.pos   = '0;
					n.lex   = LX_WHOLE;
				end else if (trm) begin
					n.lex = LX_IDLE;
					again = 1'b1;
				end
			end
			default: begin
				n.lex = LX_IDLE;
				n     = structural(n, c);
			end
		endcase
		return n;
	endfunction

	assign accept = in_valid && en;

	// Next state: up to three looks at one byte, then the end-of-tree clear.
	always_comb begin
		again2  = 1'b0;
		walk_p1 = lex_pass(walk_q, text_byte, sample_first, sample_second, again1);
		walk_p2 = walk_p1;
		if (again1)
			walk_p2 = redo_pass(walk_p1, text_byte, again2);
		walk_p = again2 ? structural(walk_p2, text_byte) : walk_p2;

		walk_d = walk_q;
		if (accept)
			walk_d = last_byte ? WALK_RST : walk_p;
	end

	// Outputs: a length token when a terminator closes a length, or when the
	// tree ends with a length still open; every last byte makes a token.
	always_comb begin
		term     = (text_byte == CH_COMMA) || (text_byte == CH_CLOSE);
		add_term = (walk_q.lex inside {LX_WHOLE, LX_FRAC}) && term;
		add_last = last_byte && (walk_p.lex inside {LX_WHOLE, LX_FRAC});

		tok_valid_d      = accept && (add_term || last_byte);
		tok_frac_d       = '0;
		tok_pos_d        = '0;
		tok_side_d.whole = '0;
		if (add_term) begin
			tok_frac_d       = walk_q.frac;
			tok_pos_d        = walk_q.pos;
			tok_side_d.whole = walk_q.whole;
		end else if (add_last) begin
			tok_frac_d       = walk_p.frac;
			tok_pos_d        = walk_p.pos;
			tok_side_d.whole = walk_p.whole;
		end
		tok_side_d.last = last_byte;
		tok_side_d.pair = walk_p.pair;
		tok_side_d.ovf  = walk_p.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q       <= WALK_RST;
			tok_valid_s1 <= 1'b0;
		end else begin
			walk_q <= walk_d;
			if (en)
				tok_valid_s1 <= tok_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_frac_s1 <= tok_frac_d;
			tok_pos_s1  <= tok_pos_d;
			tok_side_s1 <= tok_side_d;
		end
	end

	assign tok_valid = tok_valid_s1;
	assign tok_frac  = tok_frac_s1;
	assign tok_pos   = tok_pos_s1;
	assign tok_side  = tok_side_s1;

endmodule

/* design/npat_frac_div.sv */
// ----------------------------------------------------------------------------
// Newick pair ancestor time: fraction converter
// Turns a kept decimal fraction f / 10^k into 32 binary fraction bits,
// rounded toward zero, by restoring division with one quotient bit a stage.
// ----------------------------------------------------------------------------
module npat_frac_div import npat_pkg::*; #(
	parameter int FRAC_W = 34,
	parameter int POS_W  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [FRAC_W-1:0]    in_frac,
	input  logic [POS_W-1:0]     in_pos,
	input  tok_side_t            in_side,
	output logic                 out_valid,
	output logic [FRAC_BITS-1:0] out_quo,
	output tok_side_t            out_side
);

	// Remainder and divisor are not needed after the final step.
	logic                 vld_s  [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s  [FRAC_BITS];
	tok_side_t            side_s [FRAC_BITS];
	logic [FRAC_W-1:0]    rem_s  [FRAC_BITS-1];
	logic [FRAC_W-1:0]    div_s  [FRAC_BITS-1];

	logic [FRAC_W-1:0] in_div;

	assign in_div = FRAC_W'(pow10(4'(in_pos)));

	for (genvar gi = 0; gi < FRAC_BITS; gi++) begin : g_step
		logic                 src_vld;
		logic [FRAC_BITS-1:0] src_quo;
		tok_side_t            src_side;
		logic [FRAC_W-1:0]    src_rem;
		logic [FRAC_W-1:0]    src_div;
		logic [FRAC_W:0]      shl;
		logic                 ge;

		if (gi == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_quo  = '0;
			assign src_side = in_side;
			assign src_rem  = in_frac;
			assign src_div  = in_div;
		end else begin : g_next
			assign src_vld  = vld_s[gi-1];
			assign src_quo  = quo_s[gi-1];
			assign src_side = side_s[gi-1];
			assign src_rem  = rem_s[gi-1];
			assign src_div  = div_s[gi-1];
		end

		assign shl = {src_rem, 1'b0};
		assign ge  = shl >= {1'b0, src_div};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[gi] <= 1'b0;
			else if (en)
				vld_s[gi] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[gi]  <= {src_quo[FRAC_BITS-2:0], ge};
				side_s[gi] <= src_side;
			end
		end

		if (gi < FRAC_BITS - 1) begin : g_carry
			// When the divisor fits, the difference is below the divisor, so the
			// low bits of the subtraction are the whole remainder.
			logic [FRAC_W-1:0] dif;

			assign dif = shl[FRAC_W-1:0] - src_div;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi] <= ge ? dif : shl[FRAC_W-1:0];
					div_s[gi] <= src_div;
				end
			end
		end
	end

	assign out_valid = vld_s[FRAC_BITS-1];
	assign out_quo   = quo_s[FRAC_BITS-1];
	assign out_side  = side_s[FRAC_BITS-1];

endmodule

/* sim/newick_pair_ancestor_time_tb.sv */
// ----------------------------------------------------------------------------
// Newick pair ancestor time: testbench
// Streams Newick tree texts into the block one character per transaction and
// checks every result against a cycle-free model of the pair search kept
// here. Directed texts cover the parsing corner cases. Register sweeps, a long
// output stall and randomly shaped trees under random idling follow.
// ----------------------------------------------------------------------------
module newick_pair_ancestor_time_tb;
	import npat_pkg::*;

	localparam int NEST_LIMIT       = 255;
	localparam int KEEP_FRAC_DIGITS = 10;
	localparam int DRAIN_CYCLES     = 40;    // Lexer, fraction divider, accumulator, margin.
	localparam int LONG_HOLD        = 300;
	localparam int RANDOM_BYTES     = 250;
	localparam int CYCLE_LIMIT      = 300000;

	localparam logic [7:0] CH_END = 8'h3B;  // ';' closes a tree; the block ignores it.

	typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	typedef struct {
		logic [TIME_W-1:0] anc_time;
		logic              found;
		logic              ovf;
	} tree_result_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata  = '0;
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TIME_W-1:0]    m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [LABEL_W-1:0]   cfg_data      = '0;

	newick_pair_ancestor_time #(
		.MAX_NESTING    (NEST_LIMIT),
		.FRACTION_DIGITS(KEEP_FRAC_DIGITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Pair search model: register copies and walk state.
	// ------------------------------------------------------------------------
	logic [LABEL_W-1:0] sample_a;
	logic [LABEL_W-1:0] sample_b;
	phase_t             walk_ph;
	lex_t               lex_md;
	int                 label_num;
	int                 whole_acc;
	logic [63:0]        frac_acc;
	int                 frac_cnt;
	logic [TIME_W-1:0]  sum_time;
	int                 nest;
	logic [LABEL_W-1:0] target_lbl;
	logic               joined;
	logic               sat_seen;

	// Results owed by the block, oldest first.
	tree_result_t tree_results_due[$];

	// Text of the tree being built.
	logic [7:0] tree_text[$];

	int         bytes_sent      = 0;
	int         trees_closed    = 0;
	int         results_checked = 0;
	int         found_count     = 0;
	int         ovf_count       = 0;
	int         errors          = 0;
	int         settings_used   = 0;
	int         cycle_count     = 0;
	int         gap_max         = 0;
	int         burst_left      = 0;
	int         noise_pct       = 0;
	int         hold_left       = 0;
	int         sink_tick       = 0;
	int         sink_period     = 4;
	int         sink_low        = 1;
	int         sink_stall_pct  = 30;
	sink_mode_t sink_mode       = SINK_ALWAYS;

	function automatic void clear_walk_state();
		walk_ph    = PH_PRE;
		lex_md     = LX_IDLE;
		label_num  = 0;
		whole_acc  = 0;
		frac_acc   = '0;
		frac_cnt   = 0;
		sum_time   = '0;
		nest       = 0;
		target_lbl = '0;
		joined     = 1'b0;
		sat_seen   = 1'b0;
	endfunction

	// Converts the kept decimal fraction to 32 binary places by long division,
	// truncating, and adds the whole branch length to the saturating sum.
	function automatic void add_branch_length();
		logic [63:0]       div;
		logic [63:0]       rem;
		logic [63:0]       quo;
		logic [TIME_W:0]   total;
		int                k;
		div = 64'd1;
		for (k = 0; k < frac_cnt && k < 15; k++)
			div = div * 64'd10;
		rem = frac_acc;
		quo = '0;
		for (k = 0; k < FRAC_BITS; k++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= div) begin
				rem = rem - div;
				quo[0] = 1'b1;
			end
		end
		total = {1'b0, sum_time} + {1'b0, WHOLE_W'(whole_acc), quo[FRAC_BITS-1:0]};
		if (total[TIME_W]) begin
			sum_time = TIME_MAX;
			sat_seen = 1'b1;
		end else begin
			sum_time = total[TIME_W-1:0];
		end
	endfunction

	function automatic void close_label();
		if (walk_ph == PH_SEEK) begin
			if (label_num == sample_a) begin
				target_lbl = sample_b;
			end else if (label_num == sample_b) begin
				target_lbl = sample_a;
			end else begin
				lex_md = LX_SKIP;
				return;
			end
			walk_ph = PH_CLIMB;
			lex_md  = LX_AWAIT;
		end else if (walk_ph == PH_SCAN && label_num == target_lbl) begin
			joined  = 1'b1;
			walk_ph = PH_DONE;
			lex_md  = LX_IDLE;
		end else begin
			lex_md = LX_SKIP;
		end
	endfunction

	function automatic void walk_structure(input logic [7:0] c);
		logic is_num;
		is_num = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
		case (walk_ph)
			PH_PRE: begin
				if (c == CH_OPEN)
					walk_ph = PH_SEEK;
			end
			PH_SEEK: begin
				if (c == CH_CLOSE) begin
					lex_md = LX_SKIP;
				end else if (is_num) begin
					label_num = c - ASCII_ZERO;
					lex_md    = LX_LABEL;
				end
			end
			PH_CLIMB: begin
				if (c == CH_COMMA) begin
					walk_ph = PH_SCAN;
					nest    = 1;
				end else if (c == CH_CLOSE) begin
					lex_md = LX_AWAIT;
				end
			end
			PH_SCAN: begin
				if (is_num) begin
					label_num = c - ASCII_ZERO;
					lex_md    = LX_LABEL;
				end else if (c == CH_OPEN) begin
					if (nest < NEST_LIMIT)
						nest++;
					else
						sat_seen = 1'b1;
				end else if (c == CH_CLOSE) begin
					if (nest <= 1) begin
						nest    = 0;
						walk_ph = PH_CLIMB;
						lex_md  = LX_AWAIT;
					end else begin
						nest--;
						lex_md = LX_SKIP;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// One lexer pass over a character; returns 1 when the character has to be
	// looked at again in the mode it left behind.
	function automatic bit lex_byte(input logic [7:0] c);
		logic ends_item;
		logic is_num;
		ends_item = (c == CH_COMMA) || (c == CH_CLOSE);
		is_num    = (c >= ASCII_ZERO) && (c <= ASCII_NINE);
		case (lex_md)
			LX_LABEL: begin
				if (is_num) begin
					label_num = label_num * 10 + (c - ASCII_ZERO);
					if (label_num > LABEL_MAX)
						label_num = LABEL_MAX;
					return 1'b0;
				end
				close_label();
				return 1'b1;
			end
			LX_SKIP: begin
				if (ends_item) begin
					lex_md = LX_IDLE;
					return 1'b1;
				end
				return 1'b0;
			end
			LX_AWAIT: begin
				if (c == CH_COLON) begin
					whole_acc = 0;
					frac_acc  = '0;
					frac_cnt  = 0;
					lex_md    = LX_WHOLE;
					return 1'b0;
				end
				if (ends_item) begin
					lex_md = LX_IDLE;
					return 1'b1;
				end
				return 1'b0;
			end
			LX_WHOLE, LX_FRAC: begin
				if (ends_item) begin
					add_branch_length();
					lex_md = LX_IDLE;
					return 1'b1;
				end
				if (is_num) begin
					if (lex_md == LX_WHOLE) begin
						whole_acc = whole_acc * 10 + (c - ASCII_ZERO);
						if (whole_acc > WHOLE_MAX) begin
							whole_acc = WHOLE_MAX;
							sat_seen  = 1'b1;
						end
					end else if (frac_cnt < KEEP_FRAC_DIGITS) begin
						frac_acc = frac_acc * 64'd10 + 64'(c - ASCII_ZERO);
						frac_cnt++;
					end
				end else if (c == CH_POINT && lex_md == LX_WHOLE) begin
					lex_md = LX_FRAC;
				end
				return 1'b0;
			end
			default: begin
				lex_md = LX_IDLE;
				walk_structure(c);
				return 1'b0;
			end
		endcase
	endfunction

	// Advances the model by one accepted character and queues the result that
	// the final character of a tree owes.
	function automatic void walk_text_byte(input logic [7:0] c, input logic last);
		tree_result_t res;
		int           pass;
		for (pass = 0; pass < 4; pass++) begin
			if (!lex_byte(c))
				break;
		end
		if (last) begin
			if (lex_md == LX_WHOLE || lex_md == LX_FRAC)
				add_branch_length();
			res.anc_time = sum_time;
			res.found    = joined;
			res.ovf      = sat_seen;
			tree_results_due.push_back(res);
			clear_walk_state();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Result checking and the receiver's stall pattern.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		tree_result_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tree_results_due.size() == 0) begin
				$error("result transaction with none outstanding: ancestor_time %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				due = tree_results_due.pop_front();
				results_checked++;
				if (due.found)
					found_count++;
				if (due.ovf)
					ovf_count++;
				if (m_axis_tdata !== due.anc_time) begin
					$error("ancestor_time: expected %h, got %h", due.anc_time, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser[0] !== due.found) begin
					$error("pair_found: expected %b, got %b", due.found, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== due.ovf) begin
					$error("overflow_seen: expected %b, got %b", due.ovf, m_axis_tuser[1]);
					errors++;
				end
			end
		end
	end

	// A pending hold always wins; otherwise the current pattern decides.
	always @(negedge clk) begin
		sink_tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_ALWAYS: m_axis_tready <= 1'b1;
				SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
				default:     m_axis_tready <= ((sink_tick % sink_period) >= sink_low);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timed out after %0d cycles with %0d results outstanding",
				CYCLE_LIMIT, tree_results_due.size());
			$display("newick_pair_ancestor_time: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driving.
	// ------------------------------------------------------------------------
	// Offers one character and waits for the transaction. Between bursts the
	// valid line drops for a random gap while the data lines carry junk.
	task automatic send_byte(input logic [7:0] c, input logic last);
		int n;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				n = $urandom_range(1, gap_max);
				repeat (n) begin
					@(negedge clk);
					s_axis_tvalid <= 1'b0;
					s_axis_tdata  <= 8'($urandom);
					s_axis_tlast  <= 1'($urandom);
				end
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		walk_text_byte(c, last);
		bytes_sent++;
		if (last)
			trees_closed++;
	endtask

	task automatic send_text(input logic end_mark);
		int i;
		for (i = 0; i < tree_text.size(); i++)
			send_byte(tree_text[i], end_mark && (i == tree_text.size() - 1));
	endtask

	// Lets the block run dry so that the registers may be rewritten.
	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tree_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_sample(input logic [CFG_IDX_W-1:0] idx, input logic [LABEL_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_SAMPLE_FIRST)
			sample_a = val;
		else
			sample_b = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic shuffle_idling();
		gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		burst_left = 0;
		case ($urandom_range(0, 2))
			0: sink_mode = SINK_ALWAYS;
			1: begin
				sink_mode      = SINK_RANDOM;
				sink_stall_pct = $urandom_range(10, 70);
			end
			default: begin
				sink_mode   = SINK_PATTERN;
				sink_period = $urandom_range(2, 9);
				sink_low    = $urandom_range(1, sink_period - 1);
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Tree text construction.
	// ------------------------------------------------------------------------
	// Noise, when enabled, slips random bytes in front of characters.
	task automatic put_char(input logic [7:0] c);
		if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
			tree_text.push_back(8'($urandom_range(0, 255)));
		tree_text.push_back(c);
	endtask

	task automatic queue_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_num(input longint v);
		queue_str($sformatf("%0d", v));
	endtask

	task automatic run_text(input string s);
		tree_text.delete();
		queue_str(s);
		send_text(1'b1);
	endtask

	function automatic string label_text(input logic [LABEL_W-1:0] v);
		return (v == LABEL_MAX) ? "123456789" : $sformatf("%0d", v);
	endfunction

	// Optional branch length: sometimes missing, sometimes with a huge whole
	// part, a long fraction or a stray sign or exponent letter.
	task automatic put_length();
		string strays;
		int    k;
		strays = "e-+E.";
		if ($urandom_range(0, 9) == 0)
			return;
		put_char(CH_COLON);
		case ($urandom_range(0, 9))
			0: ;
			1: put_num($urandom_range(60000, 99999));
			2: put_num(WHOLE_MAX);
			default: put_num($urandom_range(0, 99));
		endcase
		if ($urandom_range(0, 3) != 0) begin
			put_char(CH_POINT);
			k = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 6);
			repeat (k) put_char(8'(ASCII_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 19) == 0)
			put_char(strays[$urandom_range(0, 4)]);
	endtask

	task automatic put_leaf();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: put_num(sample_a);
			4, 5, 6:    put_num(sample_b);
			7:          put_num($urandom_range(1, 30));
			8:          put_num($urandom_range(1, LABEL_MAX));
			default:    put_num($urandom_range(16384, 999999));
		endcase
		if ($urandom_range(0, 4) == 0) begin
			put_char(CH_POINT);
			put_num($urandom_range(0, 99));
		end
		put_length();
	endtask

	// Builds one random tree without recursion: kids[] counts the children
	// already placed at each open level.
	task automatic gen_tree(input int max_depth, input int max_kids, input int size_cap);
		int   kids [0:15];
		int   depth;
		logic closing;
		logic [7:0] junk;
		tree_text.delete();
		repeat ($urandom_range(0, 3)) begin
			junk = 8'($urandom_range(0, 255));
			put_char((junk == CH_OPEN) ? CH_CLOSE : junk);
		end
		put_char(CH_OPEN);
		depth   = 1;
		kids[1] = 0;
		while (depth > 0) begin
			if (depth < max_depth && tree_text.size() < size_cap
					&& $urandom_range(0, 2) == 0) begin
				put_char(CH_OPEN);
				depth++;
				kids[depth] = 0;
			end else begin
				put_leaf();
				kids[depth]++;
				closing = 1'b1;
				while (closing && depth > 0) begin
					if (kids[depth] < max_kids && tree_text.size() < size_cap
							&& (kids[depth] < 2 || $urandom_range(0, 1) == 1)) begin
						put_char(CH_COMMA);
						closing = 1'b0;
					end else begin
						put_char(CH_CLOSE);
						if ($urandom_range(0, 4) == 0)
							put_num($urandom_range(1, 50));
						put_length();
						depth--;
						if (depth > 0)
							kids[depth]++;
					end
				end
			end
		end
		put_char(CH_END);
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------
	// Reset values of the sample registers, with junk and a stray close paren
	// before the first open paren, high bit set on some of it.
	task automatic test_reset_samples();
		gap_max   = 0;
		sink_mode = SINK_ALWAYS;
		tree_text.delete();
		tree_text.push_back(8'hFF);
		tree_text.push_back(8'h80);
		queue_str(")(1:0.5,2:0.25);");
		send_text(1'b1);
	endtask

	task automatic test_text_cases();
		shuffle_idling();
		run_text("(7.1:1,1.9:2.75,(2.3)):3;");          // Labels with a point.
		run_text("(1,2);");                              // Missing colons.
		run_text("((5:1,1:2.5e-3+1.2.3):4,2:1):9;");    // Signs, exponent, second point.
		run_text("(2:1.00000000000001234,1:3);");        // Fraction longer than kept.
		run_text("(9:1,8:2);");                          // Neither sample present.
		run_text("((1:65535.9):65535.9,2);");            // Sum saturates.
		run_text("(1:99999,2);");                        // Whole part saturates.
		run_text("(1:1,2)(3,4)1:5;");                    // Text after the pair.
		run_text("(1:,2:.75);");                         // Empty lengths.
		run_text("(1x:3,2);");                           // Label cut by a letter.
		run_text("(3:1,(4:2,1:0.5):0.25,((2))):1;");     // Climb, then a nested sibling.
		run_text("(1:0.125");                            // Length still open at the end.
	endtask

	// Sibling subtrees nested past the counter limit, once with the target
	// inside and once without.
	task automatic test_deep_nesting();
		shuffle_idling();
		tree_text.delete();
		queue_str("(1:0.5,");
		repeat (260) put_char(CH_OPEN);
		put_char(8'(ASCII_ZERO + 2));
		repeat (260) put_char(CH_CLOSE);
		put_char(CH_END);
		send_text(1'b1);
		tree_text.delete();
		queue_str("(1:1,");
		repeat (260) put_char(CH_OPEN);
		queue_str("9");
		repeat (260) put_char(CH_CLOSE);
		queue_str(":2,2:1);");
		send_text(1'b1);
	endtask

	// Register sweep: range ends, equal samples, the saturated label value
	// and a random pair, each with a matching directed tree and random trees.
	task automatic test_sample_settings();
		logic [LABEL_W-1:0] firsts  [0:6];
		logic [LABEL_W-1:0] seconds [0:6];
		int                 i;
		int                 j;
		firsts[0] = 14'd9999;  seconds[0] = 14'd1;
		firsts[1] = 14'd1;     seconds[1] = 14'd9999;
		firsts[2] = 14'd5;     seconds[2] = 14'd5;
		firsts[3] = LABEL_MAX; seconds[3] = 14'd3;
		firsts[4] = 14'd9999;  seconds[4] = 14'd9999;
		firsts[5] = 14'($urandom_range(1, 9999));
		seconds[5] = 14'($urandom_range(1, 9999));
		firsts[6] = SAMPLE_FIRST_RST;
		seconds[6] = SAMPLE_SECOND_RST;
		for (i = 0; i < 7; i++) begin
			wait_for_results();
			write_sample(REG_SAMPLE_FIRST, firsts[i]);
			write_sample(REG_SAMPLE_SECOND, seconds[i]);
			settings_used++;
			shuffle_idling();
			run_text($sformatf("(%s:1,(%s:2,7):3);",
				label_text(firsts[i]), label_text(seconds[i])));
			for (j = 0; j < 2; j++) begin
				gen_tree(4, 3, 40);
				send_text(1'b1);
			end
		end
	endtask

	// The receiver holds off for a long stretch while short trees keep coming,
	// so the output register fills and the block has to stall its input.
	task automatic test_output_backpressure();
		int i;
		wait_for_results();
		gap_max   = 0;
		sink_mode = SINK_ALWAYS;
		hold_left = LONG_HOLD;
		for (i = 0; i < 16; i++)
			run_text($sformatf("(%0d:1.5,%0d:0.5);", sample_a, sample_b));
	endtask

	// Mostly well-formed trees with random content; a few carry noise bytes,
	// are cut short, or run on into the next tree without a final marker.
	task automatic test_random_trees();
		int start;
		int trees;
		int shape;
		int n;
		start = bytes_sent;
		trees = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (trees % 8 == 0)
				shuffle_idling();
			shape     = $urandom_range(0, 19);
			noise_pct = (shape <= 1) ? 5 : 0;
			gen_tree($urandom_range(1, 5), $urandom_range(2, 4), $urandom_range(20, 120));
			if (shape == 2 || shape == 3) begin
				n = $urandom_range(1, tree_text.size());
				while (tree_text.size() > n)
					void'(tree_text.pop_back());
			end
			send_text(shape != 4);
			trees++;
		end
		noise_pct = 0;
		run_text("(1:1,2:1);");
	endtask

	initial begin
		sample_a = SAMPLE_FIRST_RST;
		sample_b = SAMPLE_SECOND_RST;
		clear_walk_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_samples();
		test_text_cases();
		test_deep_nesting();
		test_sample_settings();
		test_output_backpressure();
		test_random_trees();

		wait_for_results();
		$display("Sent %0d bytes in %0d trees; checked %0d results, %0d joined, %0d saturated.",
			bytes_sent, trees_closed, results_checked, found_count, ovf_count);
		$display("Ran %0d sample settings, deep nesting and a %0d-cycle output stall.",
			settings_used, LONG_HOLD);
		if (errors == 0) begin
			$display("newick_pair_ancestor_time: match");
		end else begin
			$display("newick_pair_ancestor_time: mismatch");
		end
		$finish;
	end

endmodule
